>>> rtl/core/huffman_code_builder_core_macros.svh
// Assertion macros shared by the checker files of the Huffman code builder.
// Depends on nothing; the including scope must provide clk and arst_n.
`ifndef HUFFMAN_CODE_BUILDER_CORE_MACROS_SVH
`define HUFFMAN_CODE_BUILDER_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define HCB_ASSERT_NOW(lbl, ant, con) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |-> (con)) \
		else $error("huffman_code_builder_core assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define HCB_ASSERT_NEXT(lbl, ant, con) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |=> (con)) \
		else $error("huffman_code_builder_core assertion failed");

`endif

>>> rtl/core/hcb_pkg.sv
// Package of the Huffman code builder: storage sizes, field widths, state and ALU types.
// Depends on nothing; the interfaces, the ALU and the core import it.
package hcb_pkg;

	localparam int SYM_SPACE   = 256;
	localparam int SYM_W       = 8;
	localparam int CNT_W       = 16;
	localparam int NODE_DEPTH  = 127;
	localparam int NODE_W      = 7;
	localparam int HEAP_DEPTH  = 64;
	localparam int HEAP_AW     = 6;
	localparam int STACK_DEPTH = 64;
	localparam int DEPTH_W     = 7;
	localparam int PATH_W      = 32;
	localparam int LEN_W       = 6;
	localparam int KIDS_W      = 2 * NODE_W;
	localparam int LEAF_W      = SYM_W + 1;

	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	typedef enum logic [5:0] {
		ST_IDLE, ST_CNT, ST_END, ST_ERR_OUT,
		ST_SCAN_RD, ST_SCAN_WR, ST_BUILD_INIT, ST_BUILD,
		ST_SD_CUR, ST_SD_CURW, ST_SD_L, ST_SD_LW, ST_SD_LC, ST_SD_RW, ST_SD_RC,
		ST_SD_DEC, ST_SD_SW, ST_SD_RET,
		ST_MG_CHK, ST_TK_TOP, ST_TK_LAST, ST_TK_MV,
		ST_MG_WA, ST_MG_WB, ST_MG_SUM,
		ST_PU_P, ST_PU_PW, ST_PU_CMP, ST_PU_W,
		ST_WK_ROOT, ST_WK_RW, ST_WK_NODE, ST_WK_EVAL, ST_WK_OUT, ST_WK_POP,
		ST_FIN
	} state_t;

	// Caller of the sift-down routine, so it knows where to return.
	typedef enum logic [1:0] {RET_BUILD, RET_TAKE_A, RET_TAKE_B} ret_t;

	typedef enum logic {ALU_ADD, ALU_LT} alu_op_t;

	typedef struct packed {
		alu_op_t          op;
		logic [CNT_W-1:0] a;
		logic [CNT_W-1:0] b;
	} alu_req_t;

	typedef struct packed {
		logic [CNT_W-1:0] sum;
		logic             lt;
	} alu_rsp_t;

	// One pending right branch of the tree walk.
	typedef struct packed {
		logic [NODE_W-1:0]  node;
		logic [DEPTH_W-1:0] depth;
		logic [PATH_W-1:0]  path;
	} stk_t;

endpackage

>>> rtl/core/hcb_in_if.sv
// Byte channel of the Huffman code builder: valid/ready handshake and one input byte.
// Depends on hcb_pkg.
interface hcb_in_if;
	import hcb_pkg::*;

	logic             valid;
	logic             ready;
	logic [SYM_W-1:0] symbol;
	logic             last_symbol;

	modport source(output valid, symbol, last_symbol, input ready);
	modport sink(input valid, symbol, last_symbol, output ready);

endinterface

>>> rtl/core/hcb_out_if.sv
// Code channel of the Huffman code builder: valid/ready handshake and one code result.
// Depends on hcb_pkg.
interface hcb_out_if;
	import hcb_pkg::*;

	logic              valid;
	logic              ready;
	logic [SYM_W-1:0]  code_symbol;
	logic [LEN_W-1:0]  code_length;
	logic [PATH_W-1:0] code_bits;
	logic              overflow_error;
	logic              last_code;

	modport source(output valid, code_symbol, code_length, code_bits, overflow_error,
		last_code, input ready);
	modport sink(input valid, code_symbol, code_length, code_bits, overflow_error,
		last_code, output ready);

endinterface

>>> rtl/core/hcb_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Depends on nothing.
module hcb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                             clk,
	input  logic                             we,
	input  logic [$clog2(DEPTH)-1:0]         waddr,
	input  logic [WIDTH-1:0]                 wdata,
	input  logic [$clog2(DEPTH)-1:0]         raddr,
	output logic [WIDTH-1:0]                 rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Read data lands in the cycle after the address; a read of the word being written
	// in the same cycle returns the old contents.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> rtl/core/hcb_alu.sv
// Shared add/compare unit of the Huffman code builder: one adder serves sums and less-than.
// Depends on hcb_pkg.
module hcb_alu (
	input  hcb_pkg::alu_req_t req,
	output hcb_pkg::alu_rsp_t rsp
);
	import hcb_pkg::*;

	logic [CNT_W-1:0] b_in;
	logic             cin;
	logic [CNT_W:0]   total;

	// Subtraction is addition of the inverted operand plus one; a missing carry means a < b.
	always_comb begin
		unique case (req.op)
			ALU_ADD: begin
				b_in = req.b;
				cin  = 1'b0;
			end
			ALU_LT: begin
				b_in = ~req.b;
				cin  = 1'b1;
			end
			default: begin
				b_in = req.b;
				cin  = 1'b0;
			end
		endcase
		total   = {1'b0, req.a} + {1'b0, b_in} + {{CNT_W{1'b0}}, cin};
		rsp.sum = total[CNT_W-1:0];
		rsp.lt  = ~total[CNT_W];
	end

endmodule

>>> rtl/core/huffman_code_builder_core.sv
// Huffman code builder core.
// Bytes arrive on bytes_ch (valid/ready); each accepted transaction carries one byte and a
// flag for the final byte of a sequence. Codes leave on codes_ch, one transaction per coded
// symbol in left-first depth-first leaf order, the last one marked by last_code.
// Each byte is counted by reading the frequency RAM, then writing the count back.
// After the final byte the block scans all ALPHABET counts, builds a min-heap bottom-up,
// merges the two smallest nodes until one root is left and walks the tree with an explicit
// stack. Every heap compare and every sum goes through one shared adder, and the heap and
// node stores each have a single read port, so a sift-down level reads the node and its
// children and compares their weights one after another.
// An overflowing or empty sequence yields a single result with last_code set.
// Bytes are not accepted from the final byte until the last code transaction completes.
// A stalled receiver simply holds the block in its output state; the result stays stable.
// Reset (arst_n low) clears all control state and every frequency; node and heap stores
// need no clearing because they are written before they are read.
// Depends on hcb_pkg, hcb_in_if, hcb_out_if, hcb_ram and hcb_alu.
module huffman_code_builder_core #(
	parameter int ALPHABET     = 256,
	parameter int MAX_DISTINCT = 64,
	parameter int MAX_LENGTH   = 65535,
	parameter int MAX_CODE_LEN = 32
) (
	input logic        clk,
	input logic        arst_n,
	hcb_in_if.sink     bytes_ch,
	hcb_out_if.source  codes_ch
);
	import hcb_pkg::*;

	localparam int CODE_CAP = (MAX_CODE_LEN < PATH_W) ? MAX_CODE_LEN : PATH_W;

	state_t state_q, state_d;
	ret_t   ret_q;

	// Counting state.
	logic [SYM_W-1:0]     sym_q;
	logic                 last_q;
	logic [SYM_SPACE-1:0] vld_q;
	logic [NODE_W-1:0]    distinct_q;
	logic [CNT_W-1:0]     byte_q;
	logic                 ovf_q;

	// Tree build state.
	logic [SYM_W-1:0]  scan_q;
	logic [NODE_W-1:0] nodes_q, hs_q, bi_q, idx_q, cur_q, sml_q, smn_q, tmp_q;
	logic [NODE_W-1:0] a_q, b_q, i_q;
	logic [CNT_W-1:0]  smw_q, wa_q, nw_q;

	// Tree walk state.
	logic [NODE_W-1:0]  node_q, sp_q;
	logic [DEPTH_W-1:0] depth_q;
	logic [PATH_W-1:0]  path_q;

	// Result register.
	logic [SYM_W-1:0]  osym_q;
	logic [LEN_W-1:0]  olen_q;
	logic [PATH_W-1:0] obits_q;
	logic              oerr_q, olast_q;

	// Memory ports.
	logic                     cnt_we;
	logic [SYM_W-1:0]         cnt_raddr;
	logic [CNT_W-1:0]         cnt_wdata, cnt_rdata;
	logic                     node_we;
	logic [NODE_W-1:0]        node_waddr, wgt_raddr;
	logic [CNT_W-1:0]         wgt_wdata, wgt_rdata;
	logic [KIDS_W-1:0]        kid_wdata, kid_rdata;
	logic [LEAF_W-1:0]        leaf_wdata, leaf_rdata;
	logic                     heap_we;
	logic [HEAP_AW-1:0]       heap_waddr, heap_raddr;
	logic [NODE_W-1:0]        heap_wdata, heap_rdata;
	logic                     stk_we;
	logic [$clog2(STACK_DEPTH)-1:0] stk_waddr, stk_raddr;
	stk_t                     stk_wdata, stk_rdata;

	alu_req_t alu_req;
	alu_rsp_t alu_rsp;

	// Derived values.
	logic [CNT_W-1:0]   cnt_cur, cnt_inc;
	logic               sym_ok, cnt_full, cnt_new_bad, found;
	logic [NODE_W:0]    l_idx, r_idx;
	logic               has_l, has_r, keep;
	logic [NODE_W-1:0]  p_idx;
	logic [PATH_W-1:0]  path_l, path_r;
	logic [DEPTH_W-1:0] depth_inc;

	hcb_ram #(.WIDTH(CNT_W), .DEPTH(SYM_SPACE)) u_cnt_ram (
		.clk(clk), .we(cnt_we), .waddr(sym_q), .wdata(cnt_wdata),
		.raddr(cnt_raddr), .rdata(cnt_rdata)
	);

	hcb_ram #(.WIDTH(CNT_W), .DEPTH(NODE_DEPTH)) u_wgt_ram (
		.clk(clk), .we(node_we), .waddr(node_waddr), .wdata(wgt_wdata),
		.raddr(wgt_raddr), .rdata(wgt_rdata)
	);

	hcb_ram #(.WIDTH(KIDS_W), .DEPTH(NODE_DEPTH)) u_kid_ram (
		.clk(clk), .we(node_we), .waddr(node_waddr), .wdata(kid_wdata),
		.raddr(node_q), .rdata(kid_rdata)
	);

	hcb_ram #(.WIDTH(LEAF_W), .DEPTH(NODE_DEPTH)) u_leaf_ram (
		.clk(clk), .we(node_we), .waddr(node_waddr), .wdata(leaf_wdata),
		.raddr(node_q), .rdata(leaf_rdata)
	);

	hcb_ram #(.WIDTH(NODE_W), .DEPTH(HEAP_DEPTH)) u_heap_ram (
		.clk(clk), .we(heap_we), .waddr(heap_waddr), .wdata(heap_wdata),
		.raddr(heap_raddr), .rdata(heap_rdata)
	);

	hcb_ram #(.WIDTH($bits(stk_t)), .DEPTH(STACK_DEPTH)) u_stk_ram (
		.clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
		.raddr(stk_raddr), .rdata(stk_rdata)
	);

	hcb_alu u_alu (.req(alu_req), .rsp(alu_rsp));

	// Helper values for counting, heap indexing and path extension.
	always_comb begin
		cnt_cur     = vld_q[sym_q] ? cnt_rdata : '0;
		cnt_inc     = (cnt_cur == CNT_MAX) ? cnt_cur : cnt_cur + 1'b1;
		sym_ok      = {1'b0, sym_q} < (SYM_W+1)'(ALPHABET);
		cnt_full    = byte_q >= CNT_W'(MAX_LENGTH);
		cnt_new_bad = (cnt_cur == '0) && (distinct_q >= NODE_W'(MAX_DISTINCT));
		found       = vld_q[scan_q] && (cnt_rdata != '0);
		l_idx       = {idx_q, 1'b1};
		r_idx       = l_idx + 1'b1;
		has_l       = l_idx < {1'b0, hs_q};
		has_r       = r_idx < {1'b0, hs_q};
		p_idx       = (i_q - 1'b1) >> 1;
		keep        = depth_q < DEPTH_W'(CODE_CAP);
		path_l      = keep ? {path_q[PATH_W-2:0], 1'b0} : path_q;
		path_r      = keep ? {path_q[PATH_W-2:0], 1'b1} : path_q;
		depth_inc   = depth_q + 1'b1;
	end

	// Next-state logic of the sequencer.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:       if (bytes_ch.valid) state_d = ST_CNT;
			ST_CNT:        state_d = last_q ? ST_END : ST_IDLE;
			ST_END:        state_d = (ovf_q || distinct_q == '0) ? ST_ERR_OUT : ST_SCAN_RD;
			ST_ERR_OUT:    if (codes_ch.ready) state_d = ST_FIN;
			ST_SCAN_RD:    state_d = ST_SCAN_WR;
			ST_SCAN_WR: begin
				state_d = (scan_q == SYM_W'(ALPHABET - 1)) ? ST_BUILD_INIT : ST_SCAN_RD;
			end
			ST_BUILD_INIT: state_d = ST_BUILD;
			ST_BUILD:      state_d = ST_SD_CUR;
			ST_SD_CUR:     state_d = has_l ? ST_SD_CURW : ST_SD_RET;
			ST_SD_CURW:    state_d = ST_SD_L;
			ST_SD_L:       state_d = ST_SD_LW;
			ST_SD_LW:      state_d = ST_SD_LC;
			ST_SD_LC:      state_d = has_r ? ST_SD_RW : ST_SD_DEC;
			ST_SD_RW:      state_d = ST_SD_RC;
			ST_SD_RC:      state_d = ST_SD_DEC;
			ST_SD_DEC:     state_d = (sml_q == idx_q) ? ST_SD_RET : ST_SD_SW;
			ST_SD_SW:      state_d = ST_SD_CUR;
			ST_SD_RET: begin
				unique case (ret_q)
					RET_BUILD:  state_d = (bi_q == '0) ? ST_MG_CHK : ST_BUILD;
					RET_TAKE_A: state_d = ST_TK_TOP;
					RET_TAKE_B: state_d = ST_MG_WA;
					default:    state_d = ST_MG_CHK;
				endcase
			end
			ST_MG_CHK: begin
				state_d = (hs_q > NODE_W'(1) && nodes_q < NODE_W'(NODE_DEPTH)) ?
					ST_TK_TOP : ST_WK_ROOT;
			end
			ST_TK_TOP:     state_d = ST_TK_LAST;
			ST_TK_LAST:    state_d = ST_TK_MV;
			ST_TK_MV:      state_d = ST_SD_CUR;
			ST_MG_WA:      state_d = ST_MG_WB;
			ST_MG_WB:      state_d = ST_MG_SUM;
			ST_MG_SUM:     state_d = ST_PU_P;
			ST_PU_P:       state_d = (i_q == '0) ? ST_PU_W : ST_PU_PW;
			ST_PU_PW:      state_d = ST_PU_CMP;
			ST_PU_CMP:     state_d = alu_rsp.lt ? ST_PU_P : ST_PU_W;
			ST_PU_W:       state_d = ST_MG_CHK;
			ST_WK_ROOT:    state_d = ST_WK_RW;
			ST_WK_RW:      state_d = ST_WK_NODE;
			ST_WK_NODE:    state_d = ST_WK_EVAL;
			ST_WK_EVAL:    state_d = leaf_rdata[SYM_W] ? ST_WK_OUT : ST_WK_NODE;
			ST_WK_OUT: begin
				if (codes_ch.ready) begin
					state_d = (sp_q == '0) ? ST_FIN : ST_WK_POP;
				end
			end
			ST_WK_POP:     state_d = ST_WK_NODE;
			ST_FIN:        state_d = ST_IDLE;
			default:       state_d = ST_IDLE;
		endcase
	end

	// Memory, ALU and handshake controls decoded from the state.
	always_comb begin
		cnt_we     = 1'b0;
		cnt_raddr  = scan_q;
		cnt_wdata  = cnt_inc;
		node_we    = 1'b0;
		node_waddr = nodes_q;
		wgt_raddr  = heap_rdata;
		wgt_wdata  = cnt_rdata;
		kid_wdata  = '0;
		leaf_wdata = {1'b1, scan_q};
		heap_we    = 1'b0;
		heap_waddr = nodes_q[HEAP_AW-1:0];
		heap_wdata = nodes_q;
		heap_raddr = idx_q[HEAP_AW-1:0];
		stk_we     = 1'b0;
		stk_waddr  = sp_q[$clog2(STACK_DEPTH)-1:0];
		stk_wdata  = '{node: kid_rdata[KIDS_W-1:NODE_W], depth: depth_inc, path: path_r};
		stk_raddr  = stk_waddr - 1'b1;
		alu_req    = '{op: ALU_LT, a: wgt_rdata, b: smw_q};
		unique case (state_q)
			ST_IDLE:    cnt_raddr = bytes_ch.symbol;
			ST_CNT:     cnt_we = sym_ok && !cnt_full && !cnt_new_bad;
			ST_SCAN_WR: begin
				node_we = found;
				heap_we = found;
			end
			ST_SD_L:    heap_raddr = l_idx[HEAP_AW-1:0];
			ST_SD_LC:   heap_raddr = r_idx[HEAP_AW-1:0];
			ST_SD_DEC: begin
				heap_we    = (sml_q != idx_q);
				heap_waddr = sml_q[HEAP_AW-1:0];
				heap_wdata = cur_q;
			end
			ST_SD_SW: begin
				heap_we    = 1'b1;
				heap_waddr = idx_q[HEAP_AW-1:0];
				heap_wdata = smn_q;
			end
			ST_TK_TOP:  heap_raddr = '0;
			ST_TK_LAST: heap_raddr = HEAP_AW'(hs_q - 1'b1);
			ST_TK_MV: begin
				heap_we    = 1'b1;
				heap_waddr = '0;
				heap_wdata = heap_rdata;
			end
			ST_MG_WA:   wgt_raddr = a_q;
			ST_MG_WB:   wgt_raddr = b_q;
			ST_MG_SUM: begin
				alu_req    = '{op: ALU_ADD, a: wa_q, b: wgt_rdata};
				node_we    = 1'b1;
				wgt_wdata  = alu_rsp.sum;
				kid_wdata  = {b_q, a_q};
				leaf_wdata = '0;
			end
			ST_PU_P:    heap_raddr = p_idx[HEAP_AW-1:0];
			ST_PU_CMP: begin
				alu_req    = '{op: ALU_LT, a: nw_q, b: wgt_rdata};
				heap_we    = alu_rsp.lt;
				heap_waddr = i_q[HEAP_AW-1:0];
				heap_wdata = tmp_q;
			end
			ST_PU_W: begin
				heap_we    = 1'b1;
				heap_waddr = i_q[HEAP_AW-1:0];
				heap_wdata = nodes_q;
			end
			ST_WK_ROOT: heap_raddr = '0;
			ST_WK_EVAL: stk_we = !leaf_rdata[SYM_W];
			default: begin
			end
		endcase
	end

	// Channel outputs.
	always_comb begin
		bytes_ch.ready          = (state_q == ST_IDLE);
		codes_ch.valid          = (state_q == ST_WK_OUT) || (state_q == ST_ERR_OUT);
		codes_ch.code_symbol    = osym_q;
		codes_ch.code_length    = olen_q;
		codes_ch.code_bits      = obits_q;
		codes_ch.overflow_error = oerr_q;
		codes_ch.last_code      = olast_q;
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Sequence counters and the per-symbol valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q      <= '0;
			distinct_q <= '0;
			byte_q     <= '0;
			ovf_q      <= 1'b0;
		end else if (state_q == ST_FIN) begin
			vld_q      <= '0;
			distinct_q <= '0;
			byte_q     <= '0;
			ovf_q      <= 1'b0;
		end else if (state_q == ST_CNT && sym_ok) begin
			if (cnt_full || cnt_new_bad) begin
				ovf_q <= 1'b1;
			end else begin
				if (cnt_cur == '0) begin
					distinct_q <= distinct_q + 1'b1;
				end
				vld_q[sym_q] <= 1'b1;
				byte_q       <= byte_q + 1'b1;
			end
		end
	end

	// Control registers of the build and walk sequences.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ret_q <= RET_BUILD;
			sp_q  <= '0;
		end else begin
			unique case (state_q)
				ST_BUILD:   ret_q <= RET_BUILD;
				ST_MG_CHK:  ret_q <= RET_TAKE_A;
				ST_SD_RET:  if (ret_q == RET_TAKE_A) ret_q <= RET_TAKE_B;
				ST_WK_RW:   sp_q <= '0;
				ST_WK_EVAL: if (!leaf_rdata[SYM_W]) sp_q <= sp_q + 1'b1;
				ST_WK_OUT:  if (codes_ch.ready && sp_q != '0) sp_q <= sp_q - 1'b1;
				default: begin
				end
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				sym_q  <= bytes_ch.symbol;
				last_q <= bytes_ch.last_symbol;
			end
			ST_END: begin
				scan_q  <= '0;
				nodes_q <= '0;
				osym_q  <= '0;
				olen_q  <= '0;
				obits_q <= '0;
				oerr_q  <= ovf_q;
				olast_q <= 1'b1;
			end
			ST_SCAN_WR: begin
				scan_q <= scan_q + 1'b1;
				if (found) begin
					nodes_q <= nodes_q + 1'b1;
				end
			end
			ST_BUILD_INIT: begin
				hs_q <= nodes_q;
				bi_q <= (nodes_q >> 1) + 1'b1;
			end
			ST_BUILD:   idx_q <= bi_q;
			ST_SD_CURW: cur_q <= heap_rdata;
			ST_SD_L: begin
				smw_q <= wgt_rdata;
				smn_q <= cur_q;
				sml_q <= idx_q;
			end
			ST_SD_LW:   tmp_q <= heap_rdata;
			ST_SD_LC: begin
				if (alu_rsp.lt) begin
					smw_q <= wgt_rdata;
					smn_q <= tmp_q;
					sml_q <= l_idx[NODE_W-1:0];
				end
			end
			ST_SD_RW:   tmp_q <= heap_rdata;
			ST_SD_RC: begin
				if (alu_rsp.lt) begin
					smw_q <= wgt_rdata;
					smn_q <= tmp_q;
					sml_q <= r_idx[NODE_W-1:0];
				end
			end
			ST_SD_SW:   idx_q <= sml_q;
			ST_SD_RET:  if (ret_q == RET_BUILD && bi_q != '0) bi_q <= bi_q - 1'b1;
			ST_TK_LAST: begin
				if (ret_q == RET_TAKE_A) begin
					a_q <= heap_rdata;
				end else begin
					b_q <= heap_rdata;
				end
			end
			ST_TK_MV: begin
				hs_q  <= hs_q - 1'b1;
				idx_q <= '0;
			end
			ST_MG_WB:   wa_q <= wgt_rdata;
			ST_MG_SUM: begin
				nw_q <= alu_rsp.sum;
				i_q  <= hs_q;
				hs_q <= hs_q + 1'b1;
			end
			ST_PU_PW:   tmp_q <= heap_rdata;
			ST_PU_CMP:  if (alu_rsp.lt) i_q <= p_idx;
			ST_PU_W:    nodes_q <= nodes_q + 1'b1;
			ST_WK_RW: begin
				node_q  <= heap_rdata;
				depth_q <= '0;
				path_q  <= '0;
			end
			ST_WK_EVAL: begin
				if (leaf_rdata[SYM_W]) begin
					osym_q  <= leaf_rdata[SYM_W-1:0];
					olen_q  <= keep ? LEN_W'(depth_q) : LEN_W'(CODE_CAP);
					obits_q <= path_q;
					oerr_q  <= 1'b0;
					olast_q <= (sp_q == '0);
				end else begin
					node_q  <= kid_rdata[NODE_W-1:0];
					depth_q <= depth_inc;
					path_q  <= path_l;
				end
			end
			ST_WK_POP: begin
				node_q  <= stk_rdata.node;
				depth_q <= stk_rdata.depth;
				path_q  <= stk_rdata.path;
			end
			default: begin
			end
		endcase
	end

endmodule

>>> rtl/core/hcb_checker.sv
// Port-level checker of the Huffman code builder core and the bind that attaches it.
// Depends on huffman_code_builder_core_macros.svh and huffman_code_builder_core.
`include "huffman_code_builder_core_macros.svh"

module hcb_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        byte_valid,
	input logic        byte_ready,
	input logic        code_valid,
	input logic        code_ready,
	input logic [7:0]  code_symbol,
	input logic [5:0]  code_length,
	input logic [31:0] code_bits,
	input logic        overflow_error,
	input logic        last_code
);

	// A stalled code transaction stays valid and keeps its bits, symbol and last flag.
	`HCB_ASSERT_NEXT(a_stall_hold, code_valid && !code_ready, code_valid && $stable(code_bits) && $stable(code_symbol) && $stable(last_code))

	// No byte is taken while a code is offered.
	`HCB_ASSERT_NOW(a_busy_out, code_valid, !byte_ready)

	// Each byte transaction is followed by a counting cycle with nothing offered.
	`HCB_ASSERT_NEXT(a_count_gap, byte_valid && byte_ready, !byte_ready && !code_valid)

	// An error result carries no code and closes the sequence.
	`HCB_ASSERT_NOW(a_err_last, code_valid && overflow_error, last_code && code_length == 6'd0)

endmodule

bind huffman_code_builder_core hcb_checker u_hcb_checker (
	.clk(clk),
	.arst_n(arst_n),
	.byte_valid(bytes_ch.valid),
	.byte_ready(bytes_ch.ready),
	.code_valid(codes_ch.valid),
	.code_ready(codes_ch.ready),
	.code_symbol(codes_ch.code_symbol),
	.code_length(codes_ch.code_length),
	.code_bits(codes_ch.code_bits),
	.overflow_error(codes_ch.overflow_error),
	.last_code(codes_ch.last_code)
);
